// ===== src/aabbct_pkg.sv =====
// Shared types, constants and the class-pair allow lookup for the AABB collision table.
// Used by the controller, the datapath, the top level and the checker.
package aabbct_pkg;

  // table geometry
  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int NCLASS = 11;
  localparam int ROW_W  = NCLASS;
  localparam int ALLOW_W = NCLASS * NCLASS;
  localparam int ALLOW_IDX_W = $clog2(ALLOW_W);
  localparam int MAX_RES = 30;
  localparam int CNT_W  = $clog2(MAX_RES + 1);

  // APB register map (byte address 8*i, decoded on paddr[4:3])
  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;
  localparam logic [1:0] REG_ROWS_0_3  = 2'd0;
  localparam logic [1:0] REG_ROWS_4_7  = 2'd1;
  localparam logic [1:0] REG_ROWS_8_10 = 2'd2;
  localparam int ROWS4_W = 4 * ROW_W;
  localparam int ROWS3_W = 3 * ROW_W;

  typedef logic [SLOT_W-1:0] idx_t;

  typedef enum logic [1:0] {
    ACT_ADD     = 2'd0,
    ACT_ERASE   = 2'd1,
    ACT_REWRITE = 2'd2,
    ACT_SCAN    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SELF,
    S_READ,
    S_CMP,
    S_EVA,
    S_EVB,
    S_FIN
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the input word
    logic exec;     // run add/erase/rewrite or reject, emit single result
    logic rd_self;  // read the scanned row's entry
    logic ld_self;  // latch row entry, start k at row+1
    logic rd_k;     // read entry k
    logic cmp;      // register the k->row pair test for entry k
    logic take_a;   // record event (row, k)
    logic take_b;   // record event (k, row)
    logic next_k;   // advance k
    logic finish;   // emit final result of a scan
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    action_e act;
    logic    slot_ok;   // slot in range and valid
    logic    out_free;  // output register can take a word this cycle
    logic    can_take;  // an event step can complete this cycle (recorded, or dropped at MAX_RES)
    logic    ea;        // pair test, direction row->k (combinational)
    logic    eb;        // pair test, direction k->row (combinational)
    logic    eb_q;      // registered direction k->row
    logic    k_end;     // k is the last slot
    logic    self_end;  // row is the last slot
  } sts_t;

  // allow bit for self class against other class; classes past the table deny
  function automatic logic cls_allowed(input logic [ALLOW_W-1:0] rows,
                                       input logic [3:0] self_cls,
                                       input logic [3:0] other_cls);
    logic [ALLOW_IDX_W-1:0] bit_idx;
    logic ok;
    bit_idx = ALLOW_IDX_W'(self_cls) * ALLOW_IDX_W'(NCLASS) + ALLOW_IDX_W'(other_cls);
    ok = (int'(self_cls) < NCLASS) && (int'(other_cls) < NCLASS);
    return ok && rows[bit_idx];
  endfunction

endpackage

// ===== src/aabbct_ctrl.sv =====
// Controller state machine for the AABB collision table.
// Depends on aabbct_pkg; drives cmd_t to the datapath and reads back sts_t.
module aabbct_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  aabbct_pkg::sts_t   sts_i,
  output aabbct_pkg::cmd_t   cmd_o
);
  import aabbct_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (sts_i.act == ACT_SCAN && sts_i.slot_ok) begin
          state_d = S_SELF;
        end else if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_SELF: begin
        state_d = sts_i.self_end ? S_FIN : S_READ;
      end
      S_READ: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        priority if (sts_i.ea) state_d = S_EVA;
        else if (sts_i.eb) state_d = S_EVB;
        else if (sts_i.k_end) state_d = S_FIN;
        else state_d = S_READ;
      end
      S_EVA: begin
        if (sts_i.can_take) begin
          priority if (sts_i.eb_q) state_d = S_EVB;
          else if (sts_i.k_end) state_d = S_FIN;
          else state_d = S_READ;
        end
      end
      S_EVB: begin
        if (sts_i.can_take) state_d = sts_i.k_end ? S_FIN : S_READ;
      end
      S_FIN: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        cmd_o.capture = in_valid_i;
      end
      S_EXEC: begin
        if (sts_i.act == ACT_SCAN && sts_i.slot_ok) begin
          cmd_o.rd_self = 1'b1;
        end else begin
          cmd_o.exec = sts_i.out_free;
        end
      end
      S_SELF: begin
        cmd_o.ld_self = 1'b1;
      end
      S_READ: begin
        cmd_o.rd_k = 1'b1;
      end
      S_CMP: begin
        cmd_o.cmp    = 1'b1;
        cmd_o.next_k = !sts_i.ea && !sts_i.eb && !sts_i.k_end;
      end
      S_EVA: begin
        cmd_o.take_a = sts_i.can_take;
        cmd_o.next_k = sts_i.can_take && !sts_i.eb_q && !sts_i.k_end;
      end
      S_EVB: begin
        cmd_o.take_b = sts_i.can_take;
        cmd_o.next_k = sts_i.can_take && !sts_i.k_end;
      end
      S_FIN: begin
        cmd_o.finish = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== src/aabbct_dp.sv =====
// Datapath for the AABB collision table: entry memories, valid bits, allow
// registers, pair test, pending event and the output register. Depends on aabbct_pkg.
module aabbct_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  aabbct_pkg::cmd_t                cmd_i,
  output aabbct_pkg::sts_t                sts_o,
  // input word
  input  logic [1:0]                      action_i,
  input  logic [3:0]                      slot_i,
  input  logic signed [15:0]              rect_x_i,
  input  logic signed [15:0]              rect_y_i,
  input  logic [11:0]                     rect_w_i,
  input  logic [11:0]                     rect_h_i,
  input  logic [3:0]                      col_class_i,
  input  logic                            notify_i,
  input  logic                            hit_flag_i,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [aabbct_pkg::ADDR_W-1:0]   paddr,
  input  logic [aabbct_pkg::DATA_W-1:0]   pwdata,
  output logic [aabbct_pkg::DATA_W-1:0]   prdata,
  // result word
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      status_o,
  output logic                            is_event_o,
  output logic [3:0]                      self_slot_o,
  output logic [3:0]                      other_slot_o,
  output logic                            last_o
);
  import aabbct_pkg::*;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [11:0]        w;
    logic [11:0]        h;
    logic               hit;
  } geom_t;

  typedef struct packed {
    logic [3:0] cls;
    logic       notify;
  } attr_t;

  // captured input word
  action_e            act_q;
  logic [3:0]         slot_q;
  logic signed [15:0] x_q, y_q;
  logic [11:0]        w_q, h_q;
  logic [3:0]         cls_q;
  logic               notify_q, hit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q    <= action_e'(action_i);
      slot_q   <= slot_i;
      x_q      <= rect_x_i;
      y_q      <= rect_y_i;
      w_q      <= rect_w_i;
      h_q      <= rect_h_i;
      cls_q    <= col_class_i;
      notify_q <= notify_i;
      hit_q    <= hit_flag_i;
    end
  end

  // allow registers
  logic [ROWS4_W-1:0] rows_0_3_q, rows_4_7_q;
  logic [ROWS3_W-1:0] rows_8_10_q;
  logic [ALLOW_W-1:0] allow_rows;
  logic               cfg_wr;

  assign cfg_wr     = psel && penable && pwrite;
  assign allow_rows = {rows_8_10_q, rows_4_7_q, rows_0_3_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_0_3_q  <= '0;
      rows_4_7_q  <= '0;
      rows_8_10_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        REG_ROWS_0_3:  rows_0_3_q  <= pwdata[ROWS4_W-1:0];
        REG_ROWS_4_7:  rows_4_7_q  <= pwdata[ROWS4_W-1:0];
        REG_ROWS_8_10: rows_8_10_q <= pwdata[ROWS3_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[4:3])
      REG_ROWS_0_3:  prdata = DATA_W'(rows_0_3_q);
      REG_ROWS_4_7:  prdata = DATA_W'(rows_4_7_q);
      REG_ROWS_8_10: prdata = DATA_W'(rows_8_10_q);
      default:       prdata = '0;
    endcase
  end

  // valid bits and lowest free slot
  logic [SLOTS-1:0] valid_q;
  logic             free_any;
  idx_t             free_idx;
  idx_t             s_idx;
  logic             slot_ok;

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = idx_t'(i);
      end
    end
  end

  assign s_idx   = idx_t'(slot_q);
  assign slot_ok = (int'(slot_q) < SLOTS) && valid_q[s_idx];

  logic do_add, do_erase, do_rewrite;
  assign do_add     = cmd_i.exec && act_q == ACT_ADD && free_any;
  assign do_erase   = cmd_i.exec && act_q == ACT_ERASE && slot_ok;
  assign do_rewrite = cmd_i.exec && act_q == ACT_REWRITE && slot_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (do_add) begin
      valid_q[free_idx] <= 1'b1;
    end else if (do_erase) begin
      valid_q[s_idx] <= 1'b0;
    end
  end

  // entry memories: one write port, one registered read port
  geom_t geom_mem [SLOTS];
  attr_t attr_mem [SLOTS];
  geom_t geom_wd, geom_rd_q;
  attr_t attr_rd_q;
  idx_t  geom_wa, rd_addr;
  idx_t  k_q;
  logic  rd_en;

  assign geom_wa = do_add ? free_idx : s_idx;
  assign geom_wd = '{x: x_q, y: y_q, w: w_q, h: h_q, hit: do_add ? 1'b0 : hit_q};
  assign rd_en   = cmd_i.rd_self || cmd_i.rd_k;
  assign rd_addr = cmd_i.rd_self ? s_idx : k_q;

  always_ff @(posedge clk_i) begin
    if (do_add || do_rewrite) geom_mem[geom_wa] <= geom_wd;
    if (do_add) attr_mem[free_idx] <= '{cls: cls_q, notify: notify_q};
    if (rd_en) begin
      geom_rd_q <= geom_mem[rd_addr];
      attr_rd_q <= attr_mem[rd_addr];
    end
  end

  // scanned row entry
  geom_t self_geom_q;
  attr_t self_attr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_self) begin
      self_geom_q <= geom_rd_q;
      self_attr_q <= attr_rd_q;
    end
  end

  // column counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.ld_self) begin
      k_q <= idx_t'(s_idx + 1'b1);
    end else if (cmd_i.next_k) begin
      k_q <= idx_t'(k_q + 1'b1);
    end
  end

  // pair test: x inclusive both sides, y inclusive at top, exclusive at bottom
  logic signed [16:0] ax, ay, bx, by, a_xe, a_ye, b_xe, b_ye;
  logic               overlap, pair_live, ea, eb;
  logic               eb_q;

  always_comb begin
    ax   = {self_geom_q.x[15], self_geom_q.x};
    ay   = {self_geom_q.y[15], self_geom_q.y};
    bx   = {geom_rd_q.x[15], geom_rd_q.x};
    by   = {geom_rd_q.y[15], geom_rd_q.y};
    a_xe = ax + $signed({5'd0, self_geom_q.w});
    a_ye = ay + $signed({5'd0, self_geom_q.h});
    b_xe = bx + $signed({5'd0, geom_rd_q.w});
    b_ye = by + $signed({5'd0, geom_rd_q.h});
    overlap   = (a_xe >= bx) && (ax <= b_xe) && (a_ye >= by) && (ay < b_ye);
    pair_live = valid_q[k_q] && !self_geom_q.hit && !geom_rd_q.hit && overlap;
    ea = pair_live && self_attr_q.notify &&
         cls_allowed(allow_rows, self_attr_q.cls, attr_rd_q.cls);
    eb = pair_live && attr_rd_q.notify &&
         cls_allowed(allow_rows, attr_rd_q.cls, self_attr_q.cls);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp) begin
      eb_q <= eb;
    end
  end

  // pending event: held back one step so the final one can carry last
  logic             pend_v_q;
  idx_t             pend_self_q, pend_other_q;
  logic [CNT_W-1:0] n_q;
  logic             room, take;
  idx_t             new_self, new_other;
  logic             out_valid_q, out_free;

  assign room      = n_q < CNT_W'(MAX_RES);
  assign take      = (cmd_i.take_a || cmd_i.take_b) && room;
  assign new_self  = cmd_i.take_a ? s_idx : k_q;
  assign new_other = cmd_i.take_a ? k_q : s_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      n_q      <= '0;
    end else if (cmd_i.ld_self) begin
      pend_v_q <= 1'b0;
      n_q      <= '0;
    end else if (take) begin
      pend_v_q <= 1'b1;
      n_q      <= CNT_W'(n_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      pend_self_q  <= new_self;
      pend_other_q <= new_other;
    end
  end

  // result word selection
  logic    emit;
  status_e o_status;
  logic    o_ev, o_last;
  logic [3:0] o_self, o_other;

  always_comb begin
    emit     = 1'b0;
    o_status = ST_OK;
    o_ev     = 1'b0;
    o_self   = '0;
    o_other  = '0;
    o_last   = 1'b1;
    priority if (cmd_i.exec) begin
      emit = 1'b1;
      priority if (act_q == ACT_ADD) begin
        if (free_any) o_self = 4'(free_idx);
        else o_status = ST_FULL;
      end else if (!slot_ok) begin
        o_status = ST_EMPTY;
        o_self   = slot_q;
      end else begin
        o_self = slot_q;
      end
    end else if (take && pend_v_q) begin
      emit    = 1'b1;
      o_ev    = 1'b1;
      o_self  = 4'(pend_self_q);
      o_other = 4'(pend_other_q);
      o_last  = 1'b0;
    end else if (cmd_i.finish) begin
      emit = 1'b1;
      if (pend_v_q) begin
        o_ev    = 1'b1;
        o_self  = 4'(pend_self_q);
        o_other = 4'(pend_other_q);
      end else begin
        o_self = slot_q;
      end
    end else begin
      emit = 1'b0;
    end
  end

  // output register
  status_e out_status_q;
  logic    out_ev_q, out_last_q;
  logic [3:0] out_self_q, out_other_q;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_status_q <= o_status;
      out_ev_q     <= o_ev;
      out_self_q   <= o_self;
      out_other_q  <= o_other;
      out_last_q   <= o_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = 2'(out_status_q);
  assign is_event_o   = out_ev_q;
  assign self_slot_o  = out_self_q;
  assign other_slot_o = out_other_q;
  assign last_o       = out_last_q;

  // status to controller
  always_comb begin
    sts_o.act      = act_q;
    sts_o.slot_ok  = slot_ok;
    sts_o.out_free = out_free;
    sts_o.can_take = !room || !pend_v_q || out_free;
    sts_o.ea       = ea;
    sts_o.eb       = eb;
    sts_o.eb_q     = eb_q;
    sts_o.k_end    = (k_q == idx_t'(SLOTS - 1));
    sts_o.self_end = (s_idx == idx_t'(SLOTS - 1));
  end

endmodule

// ===== src/aabb_collision_table.sv =====
// Top level of the AABB collision table: controller plus datapath, APB config port.
// Depends on aabbct_pkg, aabbct_ctrl and aabbct_dp.
//
// Usage: an input word (action, slot, rectangle, class, notify, hit flag) is
// taken when in_valid_i is high and in_stall_o is low. One word is worked on
// at a time; in_stall_o stays high until its final result sits in the output
// register. Results leave on out_valid_o / out_stall_i; last_o marks the final
// result word of an input word.
// Add, erase, rewrite and any reject put their one result in the output
// register from the EXEC state, once the output register is free; the
// controller then returns to idle to take the next word. A row scan fetches
// the row entry (EXEC, SELF), then reads (READ) and tests (CMP) each later
// slot, with one step per event found (EVA row->k, EVB k->row) and a FIN step
// for the final word. The entry memory is read one slot at a time through a
// registered read port.
// A stalled receiver holds the result register; every step that must emit a
// word waits while the output register stays held.
// Reset empties the table and clears the allow registers; no clearing pass
// is needed. The allow registers sit at byte addresses 0, 8 and 16 (64-bit
// data); the user must write them only while the block is idle (unenforced).
module aabb_collision_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    action_i,
  input  logic [3:0]                    slot_i,
  input  logic signed [15:0]            rect_x_i,
  input  logic signed [15:0]            rect_y_i,
  input  logic [11:0]                   rect_w_i,
  input  logic [11:0]                   rect_h_i,
  input  logic [3:0]                    col_class_i,
  input  logic                          notify_i,
  input  logic                          hit_flag_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic                          is_event_o,
  output logic [3:0]                    self_slot_o,
  output logic [3:0]                    other_slot_o,
  output logic                          last_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [aabbct_pkg::ADDR_W-1:0] paddr,
  input  logic [aabbct_pkg::DATA_W-1:0] pwdata,
  output logic [aabbct_pkg::DATA_W-1:0] prdata,
  output logic                          pready
);
  import aabbct_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  // sequencer
  aabbct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table, pair test and result register
  aabbct_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .action_i     (action_i),
    .slot_i       (slot_i),
    .rect_x_i     (rect_x_i),
    .rect_y_i     (rect_y_i),
    .rect_w_i     (rect_w_i),
    .rect_h_i     (rect_h_i),
    .col_class_i  (col_class_i),
    .notify_i     (notify_i),
    .hit_flag_i   (hit_flag_i),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .is_event_o   (is_event_o),
    .self_slot_o  (self_slot_o),
    .other_slot_o (other_slot_o),
    .last_o       (last_o)
  );

endmodule

// ===== src/aabbct_checker.sv =====
// Port-level checks for the AABB collision table, bound to the top level.
// Depends on aabbct_pkg and aabb_collision_table.
module aabbct_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic       is_event_o,
  input logic [3:0] self_slot_o,
  input logic [3:0] other_slot_o,
  input logic       last_o
);
  import aabbct_pkg::*;

  // one word in flight: the input side closes right after an accept
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while previous word in flight");

  // a stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable({status_o, is_event_o, self_slot_o, other_slot_o, last_o}))
    else $error("stalled result word changed");

  // events are ok results between two distinct slots
  a_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_event_o |-> status_o == 2'(ST_OK) && self_slot_o != other_slot_o)
    else $error("malformed event word");

  // a non-event result is always the only one of its word
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_event_o |-> last_o && other_slot_o == 4'd0 &&
      (status_o != 2'(ST_FULL) || self_slot_o == 4'd0))
    else $error("malformed single result word");

endmodule

bind aabb_collision_table aabbct_checker u_aabbct_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .is_event_o   (is_event_o),
  .self_slot_o  (self_slot_o),
  .other_slot_o (other_slot_o),
  .last_o       (last_o)
);
